// File: rtl/core/tbgc_pkg.sv
package tbgc_pkg;

  localparam int COUNT_BITS = 12;
  localparam int CNT_MAX    = (1 << COUNT_BITS) - 1;

  // configuration registers
  localparam int REG_W     = 12;
  localparam int REG_COUNT = 5;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LONG_HOLD = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_VLONG_EXT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DBL_WIN   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BOTH_HOLD = 3'd4;

  localparam logic [REG_W-1:0] RST_DEBOUNCE  = 12'd3;
  localparam logic [REG_W-1:0] RST_LONG_HOLD = 12'd200;
  localparam logic [REG_W-1:0] RST_VLONG_EXT = 12'd300;
  localparam logic [REG_W-1:0] RST_DBL_WIN   = 12'd50;
  localparam logic [REG_W-1:0] RST_BOTH_HOLD = 12'd300;

  // item kinds
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam int PINS_W = 2;

  // event codes
  localparam int EV_W = 4;
  localparam logic [EV_W-1:0] EV_SHORT       = 4'd0;
  localparam logic [EV_W-1:0] EV_DOUBLE      = 4'd1;
  localparam logic [EV_W-1:0] EV_LONG_HOLD   = 4'd2;
  localparam logic [EV_W-1:0] EV_LONG_PRESS  = 4'd3;
  localparam logic [EV_W-1:0] EV_VLONG_HOLD  = 4'd4;
  localparam logic [EV_W-1:0] EV_VLONG_PRESS = 4'd5;
  localparam logic [EV_W-1:0] EV_PER_BUTTON  = 4'd6;
  localparam logic [EV_W-1:0] EV_BOTH_HOLD   = 4'd12;

  localparam int MAX_RES = 6;
  localparam int EVN_W   = $clog2(MAX_RES + 1);

  // result queue
  localparam int FIFO_DEPTH = 16;
  localparam int QAW        = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_LESS  = 3'd1,
    PH_MORE  = 3'd2,
    PH_VMORE = 3'd3,
    PH_TRACK = 3'd4
  } phase_t;

  // timers: 0 button one duration, 1 button one window,
  //         2 button two duration, 3 button two window
  typedef struct packed {
    logic [PINS_W-1:0]              first_sample;
    logic [PINS_W-1:0]              stable_levels;
    logic [COUNT_BITS-1:0]          debounce_count;
    logic [3:0][COUNT_BITS-1:0]     timer_count;
    logic [3:0]                     timer_running;
    phase_t [1:0]                   press_phase;
    logic [1:0]                     awaiting_second;
    logic [1:0]                     is_pushed;
    logic                           both_tracking;
  } state_t;

  typedef struct packed {
    logic [MAX_RES-1:0][EV_W-1:0] code;
    logic [EVN_W-1:0]             n;
  } ev_list_t;

  typedef logic [REG_COUNT-1:0][REG_W-1:0] regs_t;

  function automatic logic [COUNT_BITS-1:0] load_value(logic [REG_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) w = 32'd1;
    if (w > 32'(CNT_MAX)) w = 32'(CNT_MAX);
    return w[COUNT_BITS-1:0];
  endfunction

  function automatic ev_list_t ev_add(ev_list_t l, logic [EV_W-1:0] c);
    ev_list_t r;
    r = l;
    if (r.n < (EVN_W)'(MAX_RES)) begin
      r.code[r.n] = c;
      r.n         = r.n + 1'b1;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/tbgc_if.sv
interface tbgc_item_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [tbgc_pkg::PINS_W-1:0] pins;

  modport source (output valid, output kind, output pins, input ready);
  modport sink   (input valid, input kind, input pins, output ready);
endinterface

interface tbgc_result_if;
  logic                      valid;
  logic                      ready;
  logic [tbgc_pkg::EV_W-1:0] event_code;
  logic                      last;

  modport source (output valid, output event_code, output last, input ready);
  modport sink   (input valid, input event_code, input last, output ready);
endinterface

// File: rtl/core/tbgc_step.sv
// Next-state and event logic for one item. Mirrors the handler order:
// countdown, duration/window expiries per button, then debounce resample.
module tbgc_step (
  input  tbgc_pkg::state_t              cur,
  input  tbgc_pkg::regs_t               regs,
  input  logic                          kind,
  input  logic [tbgc_pkg::PINS_W-1:0]   pins,
  output tbgc_pkg::state_t              nxt,
  output tbgc_pkg::ev_list_t            evl
);

  always_comb begin
    tbgc_pkg::state_t   s;
    tbgc_pkg::ev_list_t l;
    logic [3:0]         pend;
    logic               deb_fire;
    logic [1:0]         valid_bits;
    logic [1:0]         changed;
    logic [tbgc_pkg::EV_W-1:0] base;

    s          = cur;
    l          = '0;
    pend       = '0;
    deb_fire   = 1'b0;
    valid_bits = '0;
    changed    = '0;
    base       = '0;

    if (kind == tbgc_pkg::KIND_EDGE) begin
      s.first_sample   = pins;
      s.debounce_count = tbgc_pkg::load_value(regs[tbgc_pkg::REG_DEBOUNCE]);
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (s.timer_running[i]) begin
          s.timer_count[i] = s.timer_count[i] - 1'b1;
          if (s.timer_count[i] == '0) begin
            s.timer_running[i] = 1'b0;
            pend[i]            = 1'b1;
          end
        end
      end
      if (s.debounce_count != '0) begin
        s.debounce_count = s.debounce_count - 1'b1;
        deb_fire         = (s.debounce_count == '0);
      end

      for (int b = 0; b < 2; b++) begin
        base = (tbgc_pkg::EV_W)'(b) * tbgc_pkg::EV_PER_BUTTON;
        // duration timer
        if (pend[2*b]) begin
          pend[2*b] = 1'b0;
          case (s.press_phase[b])
            tbgc_pkg::PH_LESS: begin
              s.timer_count[2*b] =
                tbgc_pkg::load_value(regs[tbgc_pkg::REG_VLONG_EXT]);
              s.timer_running[2*b] = 1'b1;
              s.press_phase[b]     = tbgc_pkg::PH_MORE;
              l = tbgc_pkg::ev_add(l, base + tbgc_pkg::EV_LONG_HOLD);
            end
            tbgc_pkg::PH_MORE: begin
              s.press_phase[b] = tbgc_pkg::PH_VMORE;
              l = tbgc_pkg::ev_add(l, base + tbgc_pkg::EV_VLONG_HOLD);
            end
            tbgc_pkg::PH_TRACK: begin
              if (b == 0) begin
                s.press_phase[0] = tbgc_pkg::PH_IDLE;
                l = tbgc_pkg::ev_add(l, tbgc_pkg::EV_BOTH_HOLD);
              end
            end
            default: ;
          endcase
        end
        // double-press window
        if (pend[2*b+1]) begin
          pend[2*b+1]            = 1'b0;
          s.awaiting_second[b]   = 1'b0;
          s.press_phase[b]       = tbgc_pkg::PH_IDLE;
          s.timer_running[2*b+1] = 1'b0;
          s.timer_count[2*b+1]   = '0;
          l = tbgc_pkg::ev_add(l, base + tbgc_pkg::EV_SHORT);
        end
      end

      if (deb_fire) begin
        valid_bits      = ~(pins ^ s.first_sample);
        changed         = (pins ^ s.stable_levels) & valid_bits;
        s.stable_levels = pins;
        for (int b = 0; b < 2; b++) begin
          base = (tbgc_pkg::EV_W)'(b) * tbgc_pkg::EV_PER_BUTTON;
          if (changed[b]) begin
            s.timer_running[2*b] = 1'b0;
            s.timer_count[2*b]   = '0;
            s.is_pushed[b]       = !pins[b];
            // both-button tracking check
            if (s.is_pushed == 2'b11) begin
              s.timer_running[2] = 1'b0;
              s.timer_count[2]   = '0;
              s.press_phase[0]   = tbgc_pkg::PH_TRACK;
              s.press_phase[1]   = tbgc_pkg::PH_IDLE;
              s.both_tracking    = 1'b1;
              s.timer_count[0]   =
                tbgc_pkg::load_value(regs[tbgc_pkg::REG_BOTH_HOLD]);
              s.timer_running[0] = 1'b1;
            end else if (s.both_tracking) begin
              s.press_phase[0]   = tbgc_pkg::PH_IDLE;
              s.press_phase[1]   = tbgc_pkg::PH_IDLE;
              s.both_tracking    = 1'b0;
              s.timer_running[0] = 1'b0;
              s.timer_count[0]   = '0;
            end
            if (!pins[b]) begin
              // push
              if (!s.both_tracking) begin
                s.press_phase[b]     = tbgc_pkg::PH_LESS;
                s.timer_count[2*b]   =
                  tbgc_pkg::load_value(regs[tbgc_pkg::REG_LONG_HOLD]);
                s.timer_running[2*b] = 1'b1;
              end
            end else begin
              // release
              case (s.press_phase[b])
                tbgc_pkg::PH_LESS: begin
                  if (!s.awaiting_second[b]) begin
                    s.awaiting_second[b]   = 1'b1;
                    s.timer_count[2*b+1]   =
                      tbgc_pkg::load_value(regs[tbgc_pkg::REG_DBL_WIN]);
                    s.timer_running[2*b+1] = 1'b1;
                  end else begin
                    s.awaiting_second[b]   = 1'b0;
                    s.timer_running[2*b+1] = 1'b0;
                    s.timer_count[2*b+1]   = '0;
                    l = tbgc_pkg::ev_add(l, base + tbgc_pkg::EV_DOUBLE);
                  end
                end
                tbgc_pkg::PH_MORE:
                  l = tbgc_pkg::ev_add(l, base + tbgc_pkg::EV_LONG_PRESS);
                tbgc_pkg::PH_VMORE:
                  l = tbgc_pkg::ev_add(l, base + tbgc_pkg::EV_VLONG_PRESS);
                default: ;
              endcase
              s.press_phase[b] = tbgc_pkg::PH_IDLE;
            end
          end
        end
      end
    end

    nxt = s;
    evl = l;
  end

endmodule

// File: rtl/core/tbgc_evq.sv
// Result queue: takes a whole event list in one write, drains one per cycle while result.ready is high.
module tbgc_evq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  tbgc_pkg::ev_list_t    wr_list,
  output logic                  has_room,
  tbgc_result_if.source         result
);

  logic [tbgc_pkg::EV_W:0]  mem [tbgc_pkg::FIFO_DEPTH];
  logic [tbgc_pkg::QAW-1:0] wr_ptr;
  logic [tbgc_pkg::QAW-1:0] rd_ptr;
  logic [tbgc_pkg::QAW:0]   count;
  logic                     pop;
  logic [tbgc_pkg::QAW:0]   add_n;

  assign pop          = result.valid && result.ready;
  assign result.valid = (count != '0);
  assign {result.event_code, result.last} = mem[rd_ptr];
  // room for a worst-case list
  assign has_room = (count <= (tbgc_pkg::QAW + 1)'(tbgc_pkg::FIFO_DEPTH - tbgc_pkg::MAX_RES));
  assign add_n    = wr_en ? (tbgc_pkg::QAW + 1)'(wr_list.n) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + add_n[tbgc_pkg::QAW-1:0];
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + add_n - (tbgc_pkg::QAW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < tbgc_pkg::MAX_RES; k++) begin
      if (wr_en && ((tbgc_pkg::EVN_W)'(k) < wr_list.n)) begin
        mem[wr_ptr + (tbgc_pkg::QAW)'(k)] <=
          {wr_list.code[k], ((tbgc_pkg::EVN_W)'(k) == wr_list.n - 1'b1)};
      end
    end
  end

endmodule

// File: rtl/core/two_button_gesture_classifier.sv
// Two-button gesture classifier. Edge and tick transactions enter on item;
// each is applied to the debounce, duration and window timers in the cycle
// it is accepted, and the gesture events it causes (up to six, the final
// one flagged by last) are queued and leave on result one per cycle while
// result.ready is high. An item is taken every cycle while the 16-entry
// result queue has room for six events; a tick's events leave one by one,
// so a slow result drain stalls item intake once the queue fills.
// Edge transactions never produce events. Registers are written through
// cfg_write/cfg_index/cfg_data; indexes beyond the last register are ignored.
module two_button_gesture_classifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [tbgc_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [tbgc_pkg::REG_W-1:0]      cfg_data,
  tbgc_item_if.sink                       item,
  tbgc_result_if.source                   result
);

  tbgc_pkg::regs_t    regs;
  tbgc_pkg::state_t   st;
  tbgc_pkg::state_t   st_next;
  tbgc_pkg::ev_list_t evl;
  logic               has_room;
  logic               take;

  assign item.ready = has_room;
  assign take       = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[tbgc_pkg::REG_DEBOUNCE]  <= tbgc_pkg::RST_DEBOUNCE;
      regs[tbgc_pkg::REG_LONG_HOLD] <= tbgc_pkg::RST_LONG_HOLD;
      regs[tbgc_pkg::REG_VLONG_EXT] <= tbgc_pkg::RST_VLONG_EXT;
      regs[tbgc_pkg::REG_DBL_WIN]   <= tbgc_pkg::RST_DBL_WIN;
      regs[tbgc_pkg::REG_BOTH_HOLD] <= tbgc_pkg::RST_BOTH_HOLD;
    end else if (cfg_write &&
                 (cfg_index < (tbgc_pkg::REG_IDX_W)'(tbgc_pkg::REG_COUNT))) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.first_sample    <= '1;
      st.stable_levels   <= '1;
      st.debounce_count  <= '0;
      st.timer_count     <= '0;
      st.timer_running   <= '0;
      st.press_phase[0]  <= tbgc_pkg::PH_IDLE;
      st.press_phase[1]  <= tbgc_pkg::PH_IDLE;
      st.awaiting_second <= '0;
      st.is_pushed       <= '0;
      st.both_tracking   <= 1'b0;
    end else if (take) begin
      st <= st_next;
    end
  end

  tbgc_step u_step (
    .cur  (st),
    .regs (regs),
    .kind (item.kind),
    .pins (item.pins),
    .nxt  (st_next),
    .evl  (evl)
  );

  tbgc_evq u_evq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (take),
    .wr_list  (evl),
    .has_room (has_room),
    .result   (result)
  );

endmodule
